/* hdl/alls_pkg.sv */
// Shared types, codes and field widths for the array linked list store.
`timescale 1ns / 1ps
package alls_pkg;

   localparam int CAPACITY_DEF   = 1024;
   localparam int DATA_WIDTH_DEF = 32;

   localparam int MODE_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int INDEX_W  = 10;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 11;

   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 64;

   localparam logic [MODE_W-1:0] MODE_PUSH      = MODE_W'(0);
   localparam logic [MODE_W-1:0] MODE_REMOVE    = MODE_W'(1);
   localparam logic [MODE_W-1:0] MODE_READ_SLOT = MODE_W'(2);
   localparam logic [MODE_W-1:0] MODE_READ_POS  = MODE_W'(3);
   localparam logic [MODE_W-1:0] MODE_CLEAR     = MODE_W'(4);

   localparam logic [STATUS_W-1:0] ST_OK     = STATUS_W'(0);
   localparam logic [STATUS_W-1:0] ST_FULL   = STATUS_W'(1);
   localparam logic [STATUS_W-1:0] ST_EMPTY  = STATUS_W'(2);
   localparam logic [STATUS_W-1:0] ST_RANGE  = STATUS_W'(3);
   localparam logic [STATUS_W-1:0] ST_ABSENT = STATUS_W'(4);

   typedef enum logic [2:0] {
      S_IDLE,
      S_PUSH_LINK,
      S_RM_FETCH,
      S_RM_FIX_NEXT,
      S_RM_FIX_PREV,
      S_NODE_READ,
      S_WALK
   } state_type;

   typedef struct packed {
      logic [INDEX_W-1:0]        index;
      logic signed [VALUE_W-1:0] value;
      logic [MODE_W-1:0]         mode;
   } req_type;

   // packed lowest field last: value_res sits in the low bits
   typedef struct packed {
      logic [COUNT_W-1:0]        live_count;
      logic [COUNT_W-1:0]        used_count;
      logic                      present;
      logic [STATUS_W-1:0]       status;
      logic signed [VALUE_W-1:0] value_res;
   } rsp_type;

   typedef struct packed {
      logic node_wr;
      logic link_wr;
   } mem_wr_type;

endpackage

/* hdl/array_linked_list_store.sv */
// Top level of the array linked list store: stream ports and result buffering.
`timescale 1ns / 1ps
// Fixed-capacity doubly linked list kept in two memories with registered reads: a node memory
// (present flag and value) and a link memory (prev and next slot). One request is worked at a
// time. Push into an empty list finishes in the idle state; any other push adds the link-fix
// state, and read-slot adds a node read. Remove fetches the node, then takes one more state for
// each neighbor whose link is rewritten; read-position walks the next links from the head, one
// read of the link memory per hop. Clear, unused modes and requests that fail their empty, range
// or fullness check finish in the idle state. Clear only resets the head, tail and count
// registers: slots are allocated in order, so a slot below the used count is always
// written since the last clear, and no sweep of the memories is needed after reset or clear.
// A finished result sits in a holding register and then the rsp output register, so a new
// request can be taken while the previous result still waits for rsp_tready.
module array_linked_list_store #(
   parameter int CAPACITY   = alls_pkg::CAPACITY_DEF,
   parameter int DATA_WIDTH = alls_pkg::DATA_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [31:0] value, [41:32] index, [47:42] zero
   input  logic [alls_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // [2:0] mode
   input  logic [alls_pkg::MODE_W-1:0]        req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [31:0] value_res, [34:32] status, [35] present, [46:36] used_count,
   // [57:47] live_count, [63:58] zero
   output logic [alls_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import alls_pkg::*;

   localparam int SLOT_W = $clog2(CAPACITY);
   localparam int PTR_W  = $clog2(CAPACITY + 1);

   req_type    req;
   logic       start;
   logic       seq_idle;
   logic       seq_done;
   rsp_type    seq_rsp;
   mem_wr_type mem_wr;

   logic [SLOT_W-1:0]     node_wr_addr, node_rd_addr, link_wr_addr, link_rd_addr;
   logic [DATA_WIDTH:0]   node_wdata, node_rdata;
   logic [2*PTR_W-1:0]    link_wdata, link_rdata;

   // result buffering: holding register, then output register
   logic    pend_valid_ff, pend_valid_in;
   rsp_type pend_ff, pend_in;
   logic    rsp_tvalid_ff, rsp_tvalid_in;
   rsp_type out_ff, out_in;
   logic    out_free;
   logic    move;

   assign req.mode  = req_tuser;
   assign req.value = req_tdata[VALUE_W-1:0];
   assign req.index = req_tdata[VALUE_W+INDEX_W-1:VALUE_W];

   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign move       = pend_valid_ff && out_free;
   // the holding register is free or empties this cycle whenever a request is taken
   assign req_tready = seq_idle && (!pend_valid_ff || out_free);
   assign start      = req_tvalid && req_tready;

   alls_seq #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .req          (req),
      .idle         (seq_idle),
      .done         (seq_done),
      .rsp          (seq_rsp),
      .mem_wr       (mem_wr),
      .node_wr_addr (node_wr_addr),
      .node_wdata   (node_wdata),
      .node_rd_addr (node_rd_addr),
      .node_rdata   (node_rdata),
      .link_wr_addr (link_wr_addr),
      .link_wdata   (link_wdata),
      .link_rd_addr (link_rd_addr),
      .link_rdata   (link_rdata)
   );

   alls_store #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_store (
      .clock        (clock),
      .mem_wr       (mem_wr),
      .node_wr_addr (node_wr_addr),
      .node_wdata   (node_wdata),
      .node_rd_addr (node_rd_addr),
      .node_rdata   (node_rdata),
      .link_wr_addr (link_wr_addr),
      .link_wdata   (link_wdata),
      .link_rd_addr (link_rd_addr),
      .link_rdata   (link_rdata)
   );

   always_comb begin
      pend_valid_in = seq_done || (pend_valid_ff && !move);
      rsp_tvalid_in = move || (rsp_tvalid_ff && !rsp_tready);
      pend_in       = seq_done ? seq_rsp : pend_ff;
      out_in        = move ? pend_ff : out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(out_ff);

endmodule

/* hdl/alls_store.sv */
// Node memory (present flag and data) and link memory (prev and next slot).
`timescale 1ns / 1ps
module alls_store #(
   parameter int CAPACITY   = alls_pkg::CAPACITY_DEF,
   parameter int DATA_WIDTH = alls_pkg::DATA_WIDTH_DEF
) (
   input  logic                                 clock,
   input  alls_pkg::mem_wr_type                 mem_wr,
   input  logic [$clog2(CAPACITY)-1:0]          node_wr_addr,
   input  logic [DATA_WIDTH:0]                  node_wdata,
   input  logic [$clog2(CAPACITY)-1:0]          node_rd_addr,
   output logic [DATA_WIDTH:0]                  node_rdata,
   input  logic [$clog2(CAPACITY)-1:0]          link_wr_addr,
   input  logic [2*$clog2(CAPACITY+1)-1:0]      link_wdata,
   input  logic [$clog2(CAPACITY)-1:0]          link_rd_addr,
   output logic [2*$clog2(CAPACITY+1)-1:0]      link_rdata
);
   import alls_pkg::*;

   localparam int PTR_W = $clog2(CAPACITY + 1);

   logic [DATA_WIDTH:0]  node_mem [CAPACITY];
   logic [2*PTR_W-1:0]   link_mem [CAPACITY];
   logic [DATA_WIDTH:0]  node_rdata_ff;
   logic [2*PTR_W-1:0]   link_rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_wr.node_wr) begin
         node_mem[node_wr_addr] <= node_wdata;
      end
      node_rdata_ff <= node_mem[node_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (mem_wr.link_wr) begin
         link_mem[link_wr_addr] <= link_wdata;
      end
      link_rdata_ff <= link_mem[link_rd_addr];
   end

   assign node_rdata = node_rdata_ff;
   assign link_rdata = link_rdata_ff;

endmodule

/* hdl/alls_seq.sv */
// Request sequencer: list registers, memory access steps and result build.
`timescale 1ns / 1ps
module alls_seq #(
   parameter int CAPACITY   = alls_pkg::CAPACITY_DEF,
   parameter int DATA_WIDTH = alls_pkg::DATA_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  alls_pkg::req_type                    req,
   output logic                                 idle,
   output logic                                 done,
   output alls_pkg::rsp_type                    rsp,
   output alls_pkg::mem_wr_type                 mem_wr,
   output logic [$clog2(CAPACITY)-1:0]          node_wr_addr,
   output logic [DATA_WIDTH:0]                  node_wdata,
   output logic [$clog2(CAPACITY)-1:0]          node_rd_addr,
   input  logic [DATA_WIDTH:0]                  node_rdata,
   output logic [$clog2(CAPACITY)-1:0]          link_wr_addr,
   output logic [2*$clog2(CAPACITY+1)-1:0]      link_wdata,
   output logic [$clog2(CAPACITY)-1:0]          link_rd_addr,
   input  logic [2*$clog2(CAPACITY+1)-1:0]      link_rdata
);
   import alls_pkg::*;

   localparam int SLOT_W = $clog2(CAPACITY);
   localparam int PTR_W  = $clog2(CAPACITY + 1);
   localparam int CMP_W  = (PTR_W > INDEX_W) ? PTR_W : INDEX_W;
   localparam logic [PTR_W-1:0] NONE = PTR_W'(CAPACITY);

   state_type state_ff, state_in;
   logic [PTR_W-1:0]   used_ff, used_in;
   logic [PTR_W-1:0]   live_ff, live_in;
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [INDEX_W-1:0] remain_ff, remain_in;
   logic [PTR_W-1:0]   pr_ff, pr_in;
   logic [PTR_W-1:0]   nx_ff, nx_in;
   logic [VALUE_W-1:0] res_ff, res_in;

   logic                         lt_used, lt_live, is_full;
   logic signed [63:0]           val_ext;
   logic [DATA_WIDTH-1:0]        store_data;
   logic signed [DATA_WIDTH-1:0] rd_data_s;
   logic signed [63:0]           rd_ext;
   logic [VALUE_W-1:0]           rd_value;
   logic                         rd_present;
   logic [PTR_W-1:0]             rd_prev, rd_next;

   assign lt_used = CMP_W'(req.index) < CMP_W'(used_ff);
   assign lt_live = CMP_W'(req.index) < CMP_W'(live_ff);
   assign is_full = (used_ff == NONE);

   // value is kept to DATA_WIDTH bits and sign-extended back on the way out
   assign val_ext    = 64'(req.value);
   assign store_data = val_ext[DATA_WIDTH-1:0];
   assign rd_data_s  = node_rdata[DATA_WIDTH-1:0];
   assign rd_ext     = 64'(rd_data_s);
   assign rd_value   = rd_ext[VALUE_W-1:0];
   assign rd_present = node_rdata[DATA_WIDTH];
   assign rd_prev    = link_rdata[2*PTR_W-1:PTR_W];
   assign rd_next    = link_rdata[PTR_W-1:0];

   assign idle = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (req.mode)
                  MODE_PUSH: begin
                     if (!is_full && live_ff != '0) begin
                        state_in = S_PUSH_LINK;
                     end
                  end
                  MODE_REMOVE: begin
                     if (used_ff != '0 && lt_used) begin
                        state_in = S_RM_FETCH;
                     end
                  end
                  MODE_READ_SLOT: begin
                     if (lt_used) begin
                        state_in = S_NODE_READ;
                     end
                  end
                  MODE_READ_POS: begin
                     if (lt_live) begin
                        state_in = (req.index == '0) ? S_NODE_READ : S_WALK;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_PUSH_LINK: state_in = S_IDLE;
         S_RM_FETCH: begin
            if (!rd_present) begin
               state_in = S_IDLE;
            end else if (rd_next < NONE) begin
               state_in = S_RM_FIX_NEXT;
            end else if (rd_prev < NONE) begin
               state_in = S_RM_FIX_PREV;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_RM_FIX_NEXT: state_in = (pr_ff < NONE) ? S_RM_FIX_PREV : S_IDLE;
         S_RM_FIX_PREV: state_in = S_IDLE;
         S_NODE_READ:   state_in = S_IDLE;
         S_WALK: begin
            if (!(rd_next < NONE)) begin
               state_in = S_IDLE;
            end else if (remain_ff == INDEX_W'(1)) begin
               state_in = S_NODE_READ;
            end else begin
               state_in = S_WALK;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      mem_wr        = '0;
      node_wr_addr  = slot_ff;
      node_wdata    = {1'b0, node_rdata[DATA_WIDTH-1:0]};
      node_rd_addr  = SLOT_W'(req.index);
      link_wr_addr  = slot_ff;
      link_wdata    = '0;
      link_rd_addr  = SLOT_W'(req.index);
      done          = 1'b0;
      rsp           = '0;
      rsp.status    = ST_OK;
      used_in       = used_ff;
      live_in       = live_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      slot_in       = slot_ff;
      remain_in     = remain_ff;
      pr_in         = pr_ff;
      nx_in         = nx_ff;
      res_in        = res_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (req.mode)
                  MODE_PUSH: begin
                     if (is_full) begin
                        done       = 1'b1;
                        rsp.status = ST_FULL;
                     end else begin
                        // new slot goes in whole; the old tail's next is fixed next cycle
                        mem_wr.node_wr = 1'b1;
                        mem_wr.link_wr = 1'b1;
                        node_wr_addr   = SLOT_W'(used_ff);
                        node_wdata     = {1'b1, store_data};
                        link_wr_addr   = SLOT_W'(used_ff);
                        link_wdata     = {(live_ff == '0) ? NONE : tail_ff, NONE};
                        link_rd_addr   = SLOT_W'(tail_ff);
                        head_in        = (live_ff == '0) ? used_ff : head_ff;
                        tail_in        = used_ff;
                        used_in        = used_ff + PTR_W'(1);
                        live_in        = live_ff + PTR_W'(1);
                        slot_in        = SLOT_W'(used_ff);
                        pr_in          = tail_ff;
                        if (live_ff == '0) begin
                           done        = 1'b1;
                           rsp.present = 1'b1;
                        end
                     end
                  end
                  MODE_REMOVE: begin
                     if (used_ff == '0) begin
                        done       = 1'b1;
                        rsp.status = ST_EMPTY;
                     end else if (!lt_used) begin
                        done       = 1'b1;
                        rsp.status = ST_RANGE;
                     end else begin
                        slot_in = SLOT_W'(req.index);
                     end
                  end
                  MODE_READ_SLOT: begin
                     if (!lt_used) begin
                        done       = 1'b1;
                        rsp.status = ST_RANGE;
                     end
                  end
                  MODE_READ_POS: begin
                     if (!lt_live) begin
                        done       = 1'b1;
                        rsp.status = ST_RANGE;
                     end else begin
                        node_rd_addr = SLOT_W'(head_ff);
                        link_rd_addr = SLOT_W'(head_ff);
                        remain_in    = req.index;
                     end
                  end
                  MODE_CLEAR: begin
                     done    = 1'b1;
                     used_in = '0;
                     live_in = '0;
                     head_in = NONE;
                     tail_in = NONE;
                  end
                  default: done = 1'b1;
               endcase
            end
         end
         S_PUSH_LINK: begin
            mem_wr.link_wr = 1'b1;
            link_wr_addr   = SLOT_W'(pr_ff);
            link_wdata     = {rd_prev, PTR_W'(slot_ff)};
            done           = 1'b1;
            rsp.present    = 1'b1;
         end
         S_RM_FETCH: begin
            if (!rd_present) begin
               done       = 1'b1;
               rsp.status = ST_ABSENT;
            end else begin
               mem_wr.node_wr = 1'b1;
               res_in         = rd_value;
               pr_in          = rd_prev;
               nx_in          = rd_next;
               if (live_ff != '0) begin
                  live_in = live_ff - PTR_W'(1);
               end
               if (!(rd_next < NONE)) begin
                  tail_in = rd_prev;
               end
               if (!(rd_prev < NONE)) begin
                  head_in = rd_next;
               end
               if (live_in == '0) begin
                  head_in = NONE;
                  tail_in = NONE;
               end
               if (rd_next < NONE) begin
                  link_rd_addr = SLOT_W'(rd_next);
               end else if (rd_prev < NONE) begin
                  link_rd_addr = SLOT_W'(rd_prev);
               end else begin
                  done          = 1'b1;
                  rsp.value_res = rd_value;
               end
            end
         end
         S_RM_FIX_NEXT: begin
            mem_wr.link_wr = 1'b1;
            link_wr_addr   = SLOT_W'(nx_ff);
            link_wdata     = {pr_ff, rd_next};
            if (pr_ff < NONE) begin
               link_rd_addr = SLOT_W'(pr_ff);
            end else begin
               done          = 1'b1;
               rsp.value_res = res_ff;
            end
         end
         S_RM_FIX_PREV: begin
            mem_wr.link_wr = 1'b1;
            link_wr_addr   = SLOT_W'(pr_ff);
            link_wdata     = {rd_prev, nx_ff};
            done           = 1'b1;
            rsp.value_res  = res_ff;
         end
         S_NODE_READ: begin
            done = 1'b1;
            if (rd_present) begin
               rsp.value_res = rd_value;
               rsp.present   = 1'b1;
            end else begin
               rsp.status = ST_ABSENT;
            end
         end
         S_WALK: begin
            if (!(rd_next < NONE)) begin
               done       = 1'b1;
               rsp.status = ST_RANGE;
            end else begin
               node_rd_addr = SLOT_W'(rd_next);
               link_rd_addr = SLOT_W'(rd_next);
               remain_in    = remain_ff - INDEX_W'(1);
            end
         end
         default: done = 1'b0;
      endcase

      rsp.used_count = COUNT_W'(used_in);
      rsp.live_count = COUNT_W'(live_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff  <= '0;
         live_ff  <= '0;
         head_ff  <= NONE;
         tail_ff  <= NONE;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         live_ff  <= live_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff   <= slot_in;
      remain_ff <= remain_in;
      pr_ff     <= pr_in;
      nx_ff     <= nx_in;
      res_ff    <= res_in;
   end

endmodule

/* test/array_linked_list_store_tb.sv */
// Self-checking testbench for the array linked list store: directed table, random traffic.
`timescale 1ns / 1ps
module array_linked_list_store_tb;
   import alls_pkg::*;

   localparam int CAP        = CAPACITY_DEF;
   localparam int NO_SLOT    = CAP;
   localparam int HALF_CLK   = 4;
   localparam int RESET_CYC  = 5;
   localparam int DRAIN_CYC  = 64;
   // ~900 requests; even if every one were a position read walking the whole list
   // with sender gaps and receiver stalls, a run stays well under this limit.
   localparam int CYCLE_LIMIT = 3000000;
   localparam int RAND_PER_PHASE = 280;

   // unused mode codes, which the block ignores
   localparam logic [MODE_W-1:0] MODE_SPARE_A = MODE_W'(5);
   localparam logic [MODE_W-1:0] MODE_SPARE_B = MODE_W'(6);
   localparam logic [MODE_W-1:0] MODE_SPARE_C = MODE_W'(7);

   localparam bit BY_MODEL = 1'b0;
   localparam bit TYPED    = 1'b1;

   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [VALUE_W-1:0]  value;
      logic [INDEX_W-1:0]  index;
      bit                  typed;
      logic [VALUE_W-1:0]  e_value;
      logic [STATUS_W-1:0] e_status;
      logic                e_present;
      logic [COUNT_W-1:0]  e_used;
      logic [COUNT_W-1:0]  e_live;
   } dir_row_type;

   localparam int DIR_ROWS_N = 25;
   localparam dir_row_type DIR_ROWS [DIR_ROWS_N] = '{
      // empty list after reset
      '{MODE_REMOVE,    32'h0,        10'd0,    TYPED, 32'h0,        ST_EMPTY,  1'b0, 11'd0, 11'd0},
      '{MODE_READ_SLOT, 32'h0,        10'd0,    TYPED, 32'h0,        ST_RANGE,  1'b0, 11'd0, 11'd0},
      '{MODE_READ_POS,  32'h0,        10'd0,    TYPED, 32'h0,        ST_RANGE,  1'b0, 11'd0, 11'd0},
      '{MODE_SPARE_A,   32'h0,        10'd0,    TYPED, 32'h0,        ST_OK,     1'b0, 11'd0, 11'd0},
      // value extremes into slots 0..3
      '{MODE_PUSH,      32'h7FFFFFFF, 10'd0,    TYPED, 32'h0,        ST_OK,     1'b1, 11'd1, 11'd1},
      '{MODE_PUSH,      32'h80000000, 10'd0,    TYPED, 32'h0,        ST_OK,     1'b1, 11'd2, 11'd2},
      '{MODE_PUSH,      32'hFFFFFFFF, 10'd0,    TYPED, 32'h0,        ST_OK,     1'b1, 11'd3, 11'd3},
      '{MODE_PUSH,      32'h0,        10'd0,    TYPED, 32'h0,        ST_OK,     1'b1, 11'd4, 11'd4},
      '{MODE_READ_SLOT, 32'h0,        10'd1,    TYPED, 32'h80000000, ST_OK,     1'b1, 11'd4, 11'd4},
      '{MODE_READ_POS,  32'h0,        10'd3,    BY_MODEL, 32'h0,     ST_OK,     1'b0, 11'd0, 11'd0},
      // position at live count, slot and remove past the used count
      '{MODE_READ_POS,  32'h0,        10'd4,    TYPED, 32'h0,        ST_RANGE,  1'b0, 11'd4, 11'd4},
      '{MODE_READ_SLOT, 32'h0,        10'd1023, TYPED, 32'h0,        ST_RANGE,  1'b0, 11'd4, 11'd4},
      '{MODE_REMOVE,    32'h0,        10'd1023, TYPED, 32'h0,        ST_RANGE,  1'b0, 11'd4, 11'd4},
      // head removal, then the same slot again
      '{MODE_REMOVE,    32'h0,        10'd0,    TYPED, 32'h7FFFFFFF, ST_OK,     1'b0, 11'd4, 11'd3},
      '{MODE_REMOVE,    32'h0,        10'd0,    TYPED, 32'h0,        ST_ABSENT, 1'b0, 11'd4, 11'd3},
      '{MODE_READ_SLOT, 32'h0,        10'd0,    TYPED, 32'h0,        ST_ABSENT, 1'b0, 11'd4, 11'd3},
      '{MODE_REMOVE,    32'h0,        10'd3,    BY_MODEL, 32'h0,     ST_OK,     1'b0, 11'd0, 11'd0},
      '{MODE_READ_POS,  32'h0,        10'd1,    BY_MODEL, 32'h0,     ST_OK,     1'b0, 11'd0, 11'd0},
      '{MODE_REMOVE,    32'h0,        10'd1,    BY_MODEL, 32'h0,     ST_OK,     1'b0, 11'd0, 11'd0},
      '{MODE_SPARE_B,   32'h55555555, 10'h2AA,  BY_MODEL, 32'h0,     ST_OK,     1'b0, 11'd0, 11'd0},
      '{MODE_SPARE_C,   32'hAAAAAAAA, 10'h155,  BY_MODEL, 32'h0,     ST_OK,     1'b0, 11'd0, 11'd0},
      // last element goes, list is empty but slots stay used
      '{MODE_REMOVE,    32'h0,        10'd2,    BY_MODEL, 32'h0,     ST_OK,     1'b0, 11'd0, 11'd0},
      '{MODE_READ_POS,  32'h0,        10'd0,    TYPED, 32'h0,        ST_RANGE,  1'b0, 11'd4, 11'd0},
      '{MODE_PUSH,      32'h12345678, 10'd0,    BY_MODEL, 32'h0,     ST_OK,     1'b0, 11'd0, 11'd0},
      '{MODE_CLEAR,     32'hFFFFFFFF, 10'd1023, TYPED, 32'h0,        ST_OK,     1'b0, 11'd0, 11'd0}
   };

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_TDATA_W-1:0]  req_tdata = '0;
   logic [MODE_W-1:0]       req_tuser = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;

   always #HALF_CLK clock = ~clock;

   array_linked_list_store dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // ---- list predictor state ----
   logic [VALUE_W-1:0] node_value [CAP];
   int                 link_next  [CAP];
   int                 link_prev  [CAP];
   bit                 node_live  [CAP];
   int                 alloc_count;
   int                 live_total;
   int                 head_ptr;
   int                 tail_ptr;

   rsp_type awaited_results [$];
   int      tx_idle_pct = 0;
   int      rx_idle_pct = 0;
   int      mismatch_count = 0;
   int      checked_count = 0;
   int      cycle_count = 0;
   int      op_count [8];
   int      status_count [8];

   function automatic void clear_list();
      for (int i = 0; i < CAP; i++) node_live[i] = 1'b0;
      alloc_count = 0;
      live_total  = 0;
      head_ptr    = NO_SLOT;
      tail_ptr    = NO_SLOT;
   endfunction

   // applies one request to the predicted list and returns the response it should produce
   function automatic rsp_type list_op_result(input logic [MODE_W-1:0] op,
                                             input logic [VALUE_W-1:0] val,
                                             input logic [INDEX_W-1:0] idx);
      rsp_type r;
      int      s;
      int      pr;
      int      nx;
      int      k;
      r = '0;
      s = int'(idx);
      case (op)
         MODE_PUSH: begin
            if (alloc_count >= CAP) begin
               r.status = ST_FULL;
            end else begin
               s = alloc_count;
               node_value[s] = val;
               link_next[s]  = NO_SLOT;
               if (live_total == 0) begin
                  head_ptr     = s;
                  link_prev[s] = NO_SLOT;
               end else begin
                  if (tail_ptr < NO_SLOT) link_next[tail_ptr] = s;
                  link_prev[s] = tail_ptr;
               end
               tail_ptr     = s;
               node_live[s] = 1'b1;
               alloc_count++;
               live_total++;
               r.present = 1'b1;
            end
         end
         MODE_REMOVE: begin
            if (alloc_count == 0) begin
               r.status = ST_EMPTY;
            end else if (s >= alloc_count) begin
               r.status = ST_RANGE;
            end else if (!node_live[s]) begin
               r.status = ST_ABSENT;
            end else begin
               pr = link_prev[s];
               nx = link_next[s];
               r.value_res = node_value[s];
               if (nx < NO_SLOT) link_prev[nx] = pr;
               if (pr < NO_SLOT) link_next[pr] = nx;
               if (nx >= NO_SLOT) tail_ptr = pr;
               if (pr >= NO_SLOT) head_ptr = nx;
               node_live[s] = 1'b0;
               if (live_total > 0) live_total--;
               if (live_total == 0) begin
                  head_ptr = NO_SLOT;
                  tail_ptr = NO_SLOT;
               end
            end
         end
         MODE_READ_SLOT: begin
            if (s >= alloc_count) begin
               r.status = ST_RANGE;
            end else if (!node_live[s]) begin
               r.status = ST_ABSENT;
            end else begin
               r.value_res = node_value[s];
               r.present   = 1'b1;
            end
         end
         MODE_READ_POS: begin
            if (s >= live_total) begin
               r.status = ST_RANGE;
            end else begin
               k = head_ptr;
               for (int hop = 0; hop < s && k < NO_SLOT; hop++) k = link_next[k];
               if (k >= NO_SLOT) begin
                  r.status = ST_RANGE;
               end else if (!node_live[k]) begin
                  r.status = ST_ABSENT;
               end else begin
                  r.value_res = node_value[k];
                  r.present   = 1'b1;
               end
            end
         end
         MODE_CLEAR: clear_list();
         default: ;
      endcase
      r.used_count = COUNT_W'(alloc_count);
      r.live_count = COUNT_W'(live_total);
      return r;
   endfunction

   // one request over the stream; the expectation is logged at the accepting edge
   task automatic send_request(input logic [MODE_W-1:0] op, input logic [VALUE_W-1:0] val,
                               input logic [INDEX_W-1:0] idx, input bit typed,
                               input rsp_type typed_rsp);
      rsp_type want;
      if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < tx_idle_pct) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= REQ_TDATA_W'({idx, val});
      do @(posedge clock); while (!req_tready);
      want = list_op_result(op, val, idx);
      if (typed) want = typed_rsp;
      awaited_results.push_back(want);
      op_count[op]++;
      status_count[want.status]++;
   endtask

   function automatic logic [VALUE_W-1:0] rand_value();
      if ($urandom_range(99) < 85) return $urandom;
      case ($urandom_range(3))
         0:       return 32'h0;
         1:       return 32'h7FFFFFFF;
         2:       return 32'h80000000;
         default: return 32'hFFFFFFFF;
      endcase
   endfunction

   // slot numbers: mostly inside the allocated range
   function automatic logic [INDEX_W-1:0] rand_slot();
      if (alloc_count > 0 && $urandom_range(99) < 80)
         return INDEX_W'($urandom_range(alloc_count - 1));
      return INDEX_W'($urandom_range(CAP - 1));
   endfunction

   // list positions: mostly short walks, a few long ones, a few out of range
   function automatic logic [INDEX_W-1:0] rand_pos();
      int roll;
      roll = $urandom_range(99);
      if (live_total > 0 && roll < 70)
         return INDEX_W'($urandom_range((live_total < 16 ? live_total : 16) - 1));
      if (live_total > 0 && roll < 90) return INDEX_W'($urandom_range(live_total - 1));
      return INDEX_W'($urandom_range(CAP - 1));
   endfunction

   task automatic random_requests(input int n_useful);
      logic [MODE_W-1:0] op;
      logic [INDEX_W-1:0] idx;
      int roll;
      int useful;
      useful = 0;
      while (useful < n_useful) begin
         roll = $urandom_range(99);
         idx  = INDEX_W'($urandom_range(CAP - 1));
         if (roll < 40) begin
            op = MODE_PUSH;
         end else if (roll < 58) begin
            op  = MODE_REMOVE;
            idx = rand_slot();
         end else if (roll < 72) begin
            op  = MODE_READ_SLOT;
            idx = rand_slot();
         end else if (roll < 90) begin
            op  = MODE_READ_POS;
            idx = rand_pos();
         end else if (roll < 93) begin
            op = MODE_CLEAR;
         end else if (roll < 96) begin
            case ($urandom_range(2))
               0:       op = MODE_SPARE_A;
               1:       op = MODE_SPARE_B;
               default: op = MODE_SPARE_C;
            endcase
         end else begin
            op = MODE_W'($urandom_range(7));   // noise: any code, any index
         end
         send_request(op, rand_value(), idx, BY_MODEL, '0);
         if (op <= MODE_CLEAR) useful++;
      end
   endtask

   // ---- response side: random back-pressure and checking ----
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[$bits(rsp_type)-1:0];
         if (awaited_results.size() == 0) begin
            $error("response with no request outstanding: %h", rsp_tdata);
            mismatch_count++;
         end else begin
            want = awaited_results.pop_front();
            checked_count++;
            if (got.value_res !== want.value_res) begin
               $error("value_res: expected %h, got %h", want.value_res, got.value_res);
               mismatch_count++;
            end
            if (got.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, got.status);
               mismatch_count++;
            end
            if (got.present !== want.present) begin
               $error("present: expected %0d, got %0d", want.present, got.present);
               mismatch_count++;
            end
            if (got.used_count !== want.used_count) begin
               $error("used_count: expected %0d, got %0d", want.used_count, got.used_count);
               mismatch_count++;
            end
            if (got.live_count !== want.live_count) begin
               $error("live_count: expected %0d, got %0d", want.live_count, got.live_count);
               mismatch_count++;
            end
         end
      end
      rsp_tready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding", cycle_count,
                  awaited_results.size());
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      rsp_type typed_rsp;
      dir_row_type row;
      foreach (op_count[i]) op_count[i] = 0;
      foreach (status_count[i]) status_count[i] = 0;
      clear_list();
      repeat (RESET_CYC) @(posedge clock);
      reset <= 1'b0;

      // phase 1: sender idles lightly, receiver stalls heavily
      tx_idle_pct = 29;
      rx_idle_pct = 56;
      for (int r = 0; r < DIR_ROWS_N; r++) begin
         row = DIR_ROWS[r];
         typed_rsp = '{live_count: row.e_live, used_count: row.e_used, present: row.e_present,
                       status: row.e_status, value_res: row.e_value};
         send_request(row.mode, row.value, row.index, row.typed, typed_rsp);
      end
      random_requests(RAND_PER_PHASE);

      // phase 2: roles swapped, starting from a cleared list
      tx_idle_pct = 56;
      rx_idle_pct = 29;
      send_request(MODE_CLEAR, rand_value(), rand_slot(), BY_MODEL, '0);
      random_requests(RAND_PER_PHASE);

      // phase 3: no idling on either side
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      random_requests(RAND_PER_PHASE);
      req_tvalid <= 1'b0;

      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);

      $display("checked %0d responses: %0d push, %0d remove, %0d slot read, %0d position read,",
               checked_count, op_count[MODE_PUSH], op_count[MODE_REMOVE],
               op_count[MODE_READ_SLOT], op_count[MODE_READ_POS]);
      $display("  %0d clear; status ok/full/empty/range/absent %0d/%0d/%0d/%0d/%0d",
               op_count[MODE_CLEAR], status_count[ST_OK], status_count[ST_FULL],
               status_count[ST_EMPTY], status_count[ST_RANGE], status_count[ST_ABSENT]);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

/* filelist.f */
hdl/alls_pkg.sv
hdl/alls_store.sv
hdl/alls_seq.sv
hdl/array_linked_list_store.sv
test/array_linked_list_store_tb.sv
